FILE: sv/jobf_pkg.sv
// ----------------------------------------------------------------------------
// jobf_pkg: shared types and constants for the JSON brace framer
// Beat payloads, the classified command passed between front and back,
// and the byte codes and buffer limits the framer works with.
// ----------------------------------------------------------------------------
package jobf_pkg;

  localparam int unsigned BUFFER_BYTES = 1024;
  localparam int unsigned CNT_W        = 10;
  localparam int unsigned CNT_MAX      = (1 << CNT_W) - 1;
  localparam int unsigned STORE_LIMIT  =
    ((BUFFER_BYTES - 1) > CNT_MAX) ? CNT_MAX : (BUFFER_BYTES - 1);

  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_LINK = 1'b1;

  // command queue depth (power of two)
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);

  typedef struct packed {
    logic        mode;
    logic [15:0] write_handle;
    logic [7:0]  data_byte;
    logic        packet_last;
  } in_item_t;

  typedef struct packed {
    logic             store_valid;
    logic [CNT_W-1:0] store_index;
    logic [7:0]       store_byte;
    logic             frame_done;
    logic [CNT_W-1:0] frame_length;
    logic             overflow;
    logic             resync;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_LINK    = 3'd0,
    CMD_FOREIGN = 3'd1,
    CMD_BLANK   = 3'd2,
    CMD_OPEN    = 3'd3,
    CMD_CLOSE   = 3'd4,
    CMD_OTHER   = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data_byte;
    logic       packet_last;
  } cmd_t;

endpackage

FILE: sv/jobf_front.sv
// ----------------------------------------------------------------------------
// jobf_front: input beat classifier
// Holds the target handle register and sorts each accepted beat into a
// command for the back end: link event, foreign handle, blank, brace, other.
// ----------------------------------------------------------------------------
module jobf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  logic              in_push,
  output logic              in_full,
  input  jobf_pkg::in_item_t in_data,
  input  logic              cmd_full,
  output logic              cmd_push,
  output jobf_pkg::cmd_t    cmd_data
);
  import jobf_pkg::*;

  logic [15:0] target_handle_r;
  logic [15:0] target_handle_nxt;
  cmd_kind_t   kind;

  always_comb begin
    target_handle_nxt = cfg_wr_en ? cfg_wr_data : target_handle_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_handle_r <= '0;
    end else begin
      target_handle_r <= target_handle_nxt;
    end
  end

  always_comb begin
    if (in_data.mode == MODE_LINK) begin
      kind = CMD_LINK;
    end else if (in_data.write_handle != target_handle_r) begin
      kind = CMD_FOREIGN;
    end else if (in_data.data_byte == CH_LF || in_data.data_byte == CH_CR ||
                 in_data.data_byte == CH_TAB) begin
      kind = CMD_BLANK;
    end else if (in_data.data_byte == CH_OPEN) begin
      kind = CMD_OPEN;
    end else if (in_data.data_byte == CH_CLOSE) begin
      kind = CMD_CLOSE;
    end else begin
      kind = CMD_OTHER;
    end
  end

  assign in_full              = cmd_full;
  assign cmd_push             = in_push & ~cmd_full;
  assign cmd_data.kind        = kind;
  assign cmd_data.data_byte   = in_data.data_byte;
  assign cmd_data.packet_last = in_data.packet_last;

endmodule

FILE: sv/jobf_cmdq.sv
// ----------------------------------------------------------------------------
// jobf_cmdq: command queue between front and back
// Short first-in first-out buffer of classified commands so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module jobf_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  jobf_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output jobf_pkg::cmd_t head,
  output logic           empty
);
  import jobf_pkg::*;

  cmd_t               mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_AW:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (CMDQ_AW+1)'(do_push) - (CMDQ_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/jobf_back.sv
// ----------------------------------------------------------------------------
// jobf_back: framing engine and result buffer
// Carries out one command a cycle while the result buffer has room, against
// nesting depth, byte count and skip state, into a two-entry result buffer.
// ----------------------------------------------------------------------------
module jobf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  jobf_pkg::cmd_t     cmd_head,
  output logic               cmd_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output jobf_pkg::out_item_t out_data
);
  import jobf_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(STORE_LIMIT);
  localparam logic [CNT_W-1:0] DMAX  = CNT_W'(CNT_MAX);

  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             skip_r, skip_nxt;

  out_item_t        obuf [2];
  logic             owr_r, owr_nxt;
  logic             ord_r, ord_nxt;
  logic [1:0]       ocnt_r, ocnt_nxt;
  logic             out_acc;
  logic             take;
  out_item_t        res;

  logic [CNT_W-1:0] d, c;
  logic             was_full;

  assign out_empty = (ocnt_r == 2'd0);
  assign out_acc   = out_pop & ~out_empty;
  assign take      = ~cmd_empty & ((ocnt_r != 2'd2) | out_acc);
  assign cmd_pop   = take;
  assign out_data  = obuf[ord_r];

  always_comb begin
    res       = '0;
    d         = depth_r;
    c         = count_r;
    was_full  = 1'b0;
    skip_nxt  = skip_r;
    unique case (cmd_head.kind)
      CMD_LINK: begin
        d        = '0;
        c        = '0;
        skip_nxt = 1'b0;
      end
      CMD_FOREIGN: begin
      end
      CMD_BLANK, CMD_OPEN, CMD_CLOSE, CMD_OTHER: begin
        if (skip_r) begin
          // drop the rest of the packet after an overflow
          if (cmd_head.packet_last) begin
            skip_nxt = 1'b0;
          end
        end else if (cmd_head.kind != CMD_BLANK) begin
          if (cmd_head.kind == CMD_OPEN) begin
            if (d == '0 && c != '0) begin
              res.resync = 1'b1;
              c          = '0;
            end
            if (d != DMAX) begin
              d = d + 1'b1;
            end
          end
          if (d != '0) begin
            if (c < LIMIT) begin
              res.store_valid = 1'b1;
              res.store_index = c;
              res.store_byte  = cmd_head.data_byte;
              c               = c + 1'b1;
            end else begin
              res.overflow = 1'b1;
              c            = '0;
              d            = '0;
              skip_nxt     = ~cmd_head.packet_last;
              was_full     = 1'b1;
            end
          end
          if (!was_full && cmd_head.kind == CMD_CLOSE) begin
            if (d != '0) begin
              d = d - 1'b1;
            end
            if (d == '0 && c != '0) begin
              res.frame_done   = 1'b1;
              res.frame_length = c;
              c                = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    depth_nxt = take ? d : depth_r;
    count_nxt = take ? c : count_r;
    if (!take) begin
      skip_nxt = skip_r;
    end
  end

  always_comb begin
    owr_nxt  = take ? ~owr_r : owr_r;
    ord_nxt  = out_acc ? ~ord_r : ord_r;
    ocnt_nxt = ocnt_r + 2'(take) - 2'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      count_r <= '0;
      skip_r  <= 1'b0;
      owr_r   <= 1'b0;
      ord_r   <= 1'b0;
      ocnt_r  <= 2'd0;
    end else begin
      depth_r <= depth_nxt;
      count_r <= count_nxt;
      skip_r  <= skip_nxt;
      owr_r   <= owr_nxt;
      ord_r   <= ord_nxt;
      ocnt_r  <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      obuf[owr_r] <= res;
    end
  end

endmodule

FILE: sv/json_object_brace_framer.sv
// ----------------------------------------------------------------------------
// json_object_brace_framer: brace-depth framer for attribute-write bytes
// Frames brace-balanced objects out of write-packet bytes and reports store
// positions, completed objects, overflow and resync events.
//
//   channel  ports                          handshake
//   config   cfg_wr_en, cfg_wr_data         write at clk edge with cfg_wr_en
//   input    in_push, in_full, in_data      beat when in_push & !in_full
//   result   out_empty, out_pop, out_data   beat when out_pop & !out_empty
//
// One beat a cycle sustained while neither side stalls. An accepted beat
// goes into the command queue at the edge that accepts it, then through
// the framing engine into the result buffer, which feeds the result ports.
// The command queue holds four beats and the result buffer two, so either
// side may stall without stopping the other until those fill.
// Reset (rst_n low at a clock edge) empties both queues and clears the
// target handle, nesting depth, byte count and skip state.
// ----------------------------------------------------------------------------
module json_object_brace_framer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                in_push,
  output logic                in_full,
  input  jobf_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output jobf_pkg::out_item_t out_data
);
  import jobf_pkg::*;

  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_head;

  jobf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .cmd_full   (cmd_full),
    .cmd_push   (cmd_push),
    .cmd_data   (cmd_in)
  );

  jobf_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd_in),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .head     (cmd_head),
    .empty    (cmd_empty)
  );

  jobf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(cmd_empty),
    .cmd_head (cmd_head),
    .cmd_pop  (cmd_pop),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

endmodule

FILE: tb/json_object_brace_framer_tb.sv
// ----------------------------------------------------------------------------
// json_object_brace_framer_tb: self-checking bench for the JSON brace framer
// Walks a short table of hand-picked bytes, then streams random packets of
// well-formed objects, noise, broken objects, link events and buffer
// overflows under several target handles. Every result beat is checked
// field by field against the table's want or a cycle-free framer model.
// ----------------------------------------------------------------------------
module json_object_brace_framer_tb;
  import jobf_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam out_item_t   NIL          = '0;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_push     = 1'b0;
  logic        in_full;
  in_item_t    in_data     = '0;
  logic        out_empty;
  logic        out_pop     = 1'b0;
  out_item_t   out_data;

  // model state
  logic [15:0] tgt_handle = '0;
  logic [9:0]  depth      = '0;
  logic [9:0]  obj_len    = '0;
  logic        skipping   = 1'b0;

  out_item_t   expected_beats [$];
  int unsigned n_beats     = 0;
  int unsigned n_checked   = 0;
  int unsigned n_bad       = 0;
  int unsigned n_frames    = 0;
  int unsigned n_overflows = 0;
  int unsigned full_stalls = 0;
  bit          snd_idle    = 1'b1;
  bit          rcv_idle    = 1'b1;
  bit          hold_req    = 1'b0;

  // target handle is zero from reset here
  dir_row_t dir_tab [20] = '{
    '{'{MODE_DATA, 16'hFFFF, CH_OPEN,  1'b0}, 1'b1, NIL},
    '{'{MODE_DATA, 16'h0000, CH_CLOSE, 1'b0}, 1'b1, NIL},
    '{'{MODE_DATA, 16'h0000, 8'h41,    1'b0}, 1'b1, NIL},
    '{'{MODE_DATA, 16'h0000, CH_OPEN,  1'b0}, 1'b1,
      '{1'b1, 10'd0, CH_OPEN, 1'b0, 10'd0, 1'b0, 1'b0}},
    '{'{MODE_DATA, 16'h0000, CH_LF,    1'b0}, 1'b1, NIL},
    '{'{MODE_DATA, 16'h0000, CH_CR,    1'b0}, 1'b1, NIL},
    '{'{MODE_DATA, 16'h0000, CH_TAB,   1'b1}, 1'b1, NIL},
    '{'{MODE_DATA, 16'h0000, 8'h00,    1'b0}, 1'b1,
      '{1'b1, 10'd1, 8'h00, 1'b0, 10'd0, 1'b0, 1'b0}},
    '{'{MODE_DATA, 16'h0000, 8'hFF,    1'b0}, 1'b1,
      '{1'b1, 10'd2, 8'hFF, 1'b0, 10'd0, 1'b0, 1'b0}},
    '{'{MODE_DATA, 16'h0000, CH_OPEN,  1'b0}, 1'b0, NIL},
    '{'{MODE_DATA, 16'h5A5A, CH_CLOSE, 1'b1}, 1'b1, NIL},
    '{'{MODE_DATA, 16'h0000, CH_CLOSE, 1'b0}, 1'b0, NIL},
    '{'{MODE_DATA, 16'h0000, CH_CLOSE, 1'b1}, 1'b0, NIL},
    '{'{MODE_DATA, 16'h0000, CH_OPEN,  1'b0}, 1'b0, NIL},
    '{'{MODE_DATA, 16'h0000, 8'h22,    1'b0}, 1'b0, NIL},
    '{'{MODE_LINK, 16'hFFFF, 8'hFF,    1'b1}, 1'b1, NIL},
    '{'{MODE_DATA, 16'h0000, CH_CLOSE, 1'b0}, 1'b1, NIL},
    '{'{MODE_LINK, 16'h0000, 8'h00,    1'b0}, 1'b1, NIL},
    '{'{MODE_DATA, 16'h0000, CH_OPEN,  1'b1}, 1'b0, NIL},
    '{'{MODE_DATA, 16'h0000, CH_CLOSE, 1'b1}, 1'b0, NIL}
  };

  json_object_brace_framer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("timeout with %0d results outstanding", expected_beats.size());
    $display("[json_object_brace_framer] ERROR");
    $finish;
  end

  // Advance the framer model by one accepted beat and return its result.
  function automatic out_item_t frame_step(input in_item_t it);
    out_item_t r;
    logic      hit_full;
    r = '0;
    hit_full = 1'b0;
    if (it.mode == MODE_LINK) begin
      depth    = '0;
      obj_len  = '0;
      skipping = 1'b0;
    end else if (it.write_handle == tgt_handle) begin
      if (skipping) begin
        if (it.packet_last) skipping = 1'b0;
      end else if (it.data_byte != CH_LF && it.data_byte != CH_CR &&
                   it.data_byte != CH_TAB) begin
        if (it.data_byte == CH_OPEN) begin
          if (depth == 0 && obj_len != 0) begin
            r.resync = 1'b1;
            obj_len  = '0;
          end
          if (depth < CNT_MAX) depth = depth + 10'd1;
        end
        if (depth != 0) begin
          if (obj_len < STORE_LIMIT) begin
            r.store_valid = 1'b1;
            r.store_index = obj_len;
            r.store_byte  = it.data_byte;
            obj_len       = obj_len + 10'd1;
          end else begin
            r.overflow = 1'b1;
            obj_len    = '0;
            depth      = '0;
            skipping   = !it.packet_last;
            hit_full   = 1'b1;
          end
        end
        if (!hit_full && it.data_byte == CH_CLOSE) begin
          if (depth != 0) depth = depth - 10'd1;
          if (depth == 0 && obj_len != 0) begin
            r.frame_done   = 1'b1;
            r.frame_length = obj_len;
            obj_len        = '0;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Offer one beat, hold it until taken, then log what it should produce.
  task automatic push_beat(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t want = '0);
    int unsigned gap;
    out_item_t   predicted;
    gap = snd_idle ? pick_gap() : 0;
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) begin
      full_stalls++;
      @(posedge clk);
    end
    predicted = frame_step(it);
    expected_beats.push_back(typed ? want : predicted);
    n_beats++;
  endtask

  task automatic send(input logic [15:0] handle, input logic [7:0] b,
                      input logic last);
    push_beat('{MODE_DATA, handle, b, last});
  endtask

  task automatic send_link();
    push_beat('{MODE_LINK, 16'($urandom), 8'($urandom), 1'($urandom)});
  endtask

  function automatic logic [15:0] other_handle();
    logic [15:0] h;
    h = 16'($urandom);
    if (h == tgt_handle) h = ~h;
    return h;
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == CH_OPEN || b == CH_CLOSE) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic drain();
    in_push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_target(input logic [15:0] h);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= h;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tgt_handle   = h;
  endtask

  // Balanced object with random content, split over packets at random.
  task automatic send_object(input int unsigned body);
    int unsigned d;
    int unsigned r;
    d = 1;
    send(tgt_handle, CH_OPEN, ($urandom_range(0, 7) == 0));
    repeat (body) begin
      r = $urandom_range(0, 99);
      if (r < 10 && d < 8) begin
        send(tgt_handle, CH_OPEN, ($urandom_range(0, 7) == 0));
        d++;
      end else if (r < 20 && d > 1) begin
        send(tgt_handle, CH_CLOSE, ($urandom_range(0, 7) == 0));
        d--;
      end else if (r < 28) begin
        case ($urandom_range(0, 2))
          0: send(tgt_handle, CH_LF, 1'b0);
          1: send(tgt_handle, CH_CR, 1'b0);
          default: send(tgt_handle, CH_TAB, 1'b0);
        endcase
      end else if (r < 35) begin
        send(other_handle(), 8'($urandom), 1'($urandom));
      end else begin
        send(tgt_handle, body_byte(), ($urandom_range(0, 7) == 0));
      end
    end
    while (d > 0) begin
      send(tgt_handle, CH_CLOSE, (d == 1));
      d--;
    end
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) begin
      push_beat('{($urandom_range(0, 15) == 0),
                  ($urandom_range(0, 1) ? tgt_handle : 16'($urandom)),
                  8'($urandom), 1'($urandom)});
    end
  endtask

  // Open an object and abandon it: link drop, or a packet ends unbalanced.
  task automatic send_broken();
    send(tgt_handle, CH_OPEN, 1'b0);
    repeat ($urandom_range(0, 6)) send(tgt_handle, body_byte(), 1'b0);
    if ($urandom_range(0, 1)) send_link();
    else send(tgt_handle, body_byte(), 1'b1);
  endtask

  // Nest past the buffer limit mid-packet; the rest of the packet is dropped.
  task automatic send_deep_overflow();
    repeat (STORE_LIMIT + 1) send(tgt_handle, CH_OPEN, 1'b0);
    repeat (3) send(tgt_handle, body_byte(), 1'b0);
    send(other_handle(), CH_OPEN, 1'b1);
    send(tgt_handle, CH_CLOSE, 1'b1);
    send_object(4);
  endtask

  // Fill the buffer with a flat object; overflow lands on the last byte.
  task automatic send_flat_overflow();
    send(tgt_handle, CH_OPEN, 1'b0);
    repeat (STORE_LIMIT - 1) send(tgt_handle, body_byte(), 1'($urandom));
    send(tgt_handle, body_byte(), 1'b1);
    send_object(3);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned stop_at;
    int unsigned r;
    stop_at = n_beats + n;
    while (n_beats < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_object($urandom_range(0, 12));
      else if (r < 85) send_noise($urandom_range(1, 6));
      else if (r < 95) send_broken();
      else send_link();
    end
  endtask

  // Result side: check each taken beat, pop with random gaps.
  initial begin
    out_item_t   want;
    int unsigned pop_gap;
    pop_gap = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (expected_beats.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("result beat with nothing pending: %p", out_data);
        end else begin
          want = expected_beats.pop_front();
          n_checked++;
          if (out_data.frame_done) n_frames++;
          if (out_data.overflow) n_overflows++;
          if (out_data.store_valid  !== want.store_valid  ||
              out_data.store_index  !== want.store_index  ||
              out_data.store_byte   !== want.store_byte   ||
              out_data.frame_done   !== want.frame_done   ||
              out_data.frame_length !== want.frame_length ||
              out_data.overflow     !== want.overflow     ||
              out_data.resync       !== want.resync) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("mismatch on result %0d", n_checked);
              $display("  want %p", want);
              $display("  got  %p", out_data);
            end
          end
        end
      end
      if (hold_req) begin
        // hold off so the input side backs up
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (pop_gap != 0) begin
        out_pop <= 1'b0;
        pop_gap--;
      end else begin
        out_pop <= 1'b1;
        pop_gap = rcv_idle ? pick_gap() : 0;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) push_beat(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    write_target(16'hFFFF);
    hold_req = 1'b1;
    run_random(200);

    write_target(16'h0000);
    snd_idle = 1'b0;
    rcv_idle = 1'b0;
    run_random(150);
    send_flat_overflow();

    write_target(16'($urandom));
    snd_idle = 1'b1;
    rcv_idle = 1'b1;
    send_deep_overflow();
    run_random(150);

    write_target(16'($urandom));
    rcv_idle = 1'b0;
    run_random(100);

    drain();
    repeat (10) @(posedge clk);

    $display("%0d input beats, %0d results checked (%0d objects, %0d overflows)",
             n_beats, n_checked, n_frames, n_overflows);
    $display("%0d cycles with input held off, %0d mismatches", full_stalls, n_bad);
    if (n_bad == 0 && expected_beats.size() == 0) begin
      $display("[json_object_brace_framer] OK");
    end else begin
      $display("[json_object_brace_framer] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/jobf_pkg.sv
sv/jobf_front.sv
sv/jobf_cmdq.sv
sv/jobf_back.sv
sv/json_object_brace_framer.sv
tb/json_object_brace_framer_tb.sv
